/* rtl/huffman_two_pass_encoder_core_macros.svh */
// Assertion helpers for the encoder checker
`ifndef HUFFMAN_TWO_PASS_ENCODER_CORE_MACROS_SVH
`define HUFFMAN_TWO_PASS_ENCODER_CORE_MACROS_SVH

// same-cycle implication
`define HUFF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("huff assertion failed");

// next-cycle implication
`define HUFF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("huff assertion failed");

`endif

/* rtl/huff_pkg.sv */
`timescale 1ns / 1ps
package huff_pkg;

  localparam int SYMBOLS     = 128;
  localparam int SYM_W       = 7;
  localparam int NODE_W      = 8;
  localparam int NODES       = 256;
  localparam int COUNT_W     = 32;
  localparam int CHUNK_W     = 32;
  localparam int CHUNK_LEN_W = 6;
  localparam int LEN_W       = 7;
  localparam int CODE_W      = 128;
  localparam int DIST_W      = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] CMD_COUNT  = 2'd0;
  localparam logic [1:0] CMD_BUILD  = 2'd1;
  localparam logic [1:0] CMD_ENCODE = 2'd2;

  typedef struct packed {
    logic [CHUNK_W-1:0]     value;
    logic [CHUNK_LEN_W-1:0] len;
    logic                   last;
  } chunk_t;

  function automatic logic is_space(input logic [SYM_W-1:0] s);
    is_space = (s == 7'd32) || ((s >= 7'd9) && (s <= 7'd13));
  endfunction

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    sat_add = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
  endfunction

endpackage

/* rtl/huff_chunk.sv */
`timescale 1ns / 1ps
module huff_chunk (
  input  logic [huff_pkg::CODE_W-1:0] bits_i,
  input  logic [huff_pkg::LEN_W-1:0]  rem_i,
  output huff_pkg::chunk_t            chunk_o
);

  logic [huff_pkg::CHUNK_LEN_W-1:0] cnt;
  logic [huff_pkg::LEN_W-1:0]       shamt;
  logic [huff_pkg::CODE_W-1:0]      shifted;
  logic [huff_pkg::CHUNK_W-1:0]     mask;

  always_comb begin
    cnt     = (rem_i > 7'd32) ? 6'd32 : rem_i[huff_pkg::CHUNK_LEN_W-1:0];
    shamt   = rem_i - {1'b0, cnt};
    shifted = bits_i >> shamt;
    mask    = (cnt == 6'd32) ? '1 : ((32'd1 << cnt) - 32'd1);
    chunk_o.value = shifted[huff_pkg::CHUNK_W-1:0] & mask;
    chunk_o.len   = cnt;
    chunk_o.last  = (rem_i <= 7'd32);
  end

endmodule

/* rtl/huffman_two_pass_encoder_core.sv */
`timescale 1ns / 1ps
// channel  | handshake                    | payload
// input    | in_valid_i / in_stall_o      | cmd_i, symbol_i
// output   | out_valid_o / out_stall_i    | code_chunk_o, chunk_length_o, last_chunk_o,
//          |                              | distinct_symbols_o
// Count: count read, write back, result. Encode: code read, then one output per
// chunk while the output is free. Build: scan of 128 counts, insertion sort over the
// queue memory (O(n^2) per pass, one pass before each merge), then one parent read
// per code bit of each symbol; all memories have registered read ports.
// Reset clears the counts and code table through per-entry valid bits at once.
// The block takes one item at a time; a stalled result holds in the output register.
module huffman_two_pass_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [6:0]  symbol_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] code_chunk_o,
  output logic [5:0]  chunk_length_o,
  output logic        last_chunk_o,
  output logic [7:0]  distinct_symbols_o
);

  typedef enum logic [24:0] {
    ST_IDLE   = 25'h0000001,
    ST_CT_WR  = 25'h0000002,
    ST_ACK    = 25'h0000004,
    ST_SC_RD  = 25'h0000008,
    ST_SC_WR  = 25'h0000010,
    ST_SO_I   = 25'h0000020,
    ST_SO_T   = 25'h0000040,
    ST_SO_TW  = 25'h0000080,
    ST_SO_J   = 25'h0000100,
    ST_SO_Q   = 25'h0000200,
    ST_SO_C   = 25'h0000400,
    ST_MG_A   = 25'h0000800,
    ST_MG_B   = 25'h0001000,
    ST_MG_C   = 25'h0002000,
    ST_MG_D   = 25'h0004000,
    ST_MG_E   = 25'h0008000,
    ST_RT_A   = 25'h0010000,
    ST_RT_B   = 25'h0020000,
    ST_CD_RD  = 25'h0040000,
    ST_CD_CHK = 25'h0080000,
    ST_CD_W   = 25'h0100000,
    ST_CD_P   = 25'h0200000,
    ST_EN_LD  = 25'h0400000,
    ST_EN_OUT = 25'h0800000,
    ST_SPARE  = 25'h1000000
  } state_e;

  localparam int CODE_E_W = huff_pkg::LEN_W + huff_pkg::CODE_W;

  state_e state_q, state_d;

  logic [huff_pkg::SYM_W-1:0]   s_q, s_d, sym_q, sym_d;
  logic                         usable_q, usable_d;
  logic [huff_pkg::DIST_W-1:0]  n_q, n_d, m_q, m_d, dist_q, dist_d;
  logic [huff_pkg::SYM_W-1:0]   i_q, i_d, j_q, j_d;
  logic [huff_pkg::NODE_W-1:0]  next_q, next_d, node_q, node_d, root_q, root_d;
  logic [huff_pkg::NODE_W-1:0]  t_q, t_d, qv_q, qv_d;
  logic [huff_pkg::COUNT_W-1:0] tw_q, tw_d;
  logic [huff_pkg::LEN_W-1:0]   len_q, len_d;
  logic [huff_pkg::CODE_W-1:0]  bits_q, bits_d;

  logic                          out_vld_q, out_vld_d;
  logic [huff_pkg::CHUNK_W-1:0]  out_chunk_q, out_chunk_d;
  logic [huff_pkg::CHUNK_LEN_W-1:0] out_len_q, out_len_d;
  logic                          out_last_q, out_last_d;
  logic [huff_pkg::DIST_W-1:0]   out_dist_q, out_dist_d;

  // count memory
  logic [huff_pkg::COUNT_W-1:0] cnt_mem [huff_pkg::SYMBOLS];
  logic [huff_pkg::SYMBOLS-1:0] cnt_vld_q;
  logic [huff_pkg::SYM_W-1:0]   cnt_raddr, cnt_waddr;
  logic [huff_pkg::COUNT_W-1:0] cnt_rd_q, cnt_wdata, cnt_val;
  logic                         cnt_vld_rd_q, cnt_we;

  // node weight memory
  logic [huff_pkg::COUNT_W-1:0] wgt_mem [huff_pkg::NODES];
  logic [huff_pkg::NODE_W-1:0]  wgt_raddr, wgt_waddr;
  logic [huff_pkg::COUNT_W-1:0] wgt_rd_q, wgt_wdata;
  logic                         wgt_we;

  // sort queue memory
  logic [huff_pkg::NODE_W-1:0]  que_mem [huff_pkg::SYMBOLS];
  logic [huff_pkg::SYM_W-1:0]   que_raddr, que_waddr;
  logic [huff_pkg::NODE_W-1:0]  que_rd_q, que_wdata;
  logic                         que_we;

  // parent memory: {branch bit, parent}
  logic [huff_pkg::NODE_W:0]    par_mem [huff_pkg::NODES];
  logic [huff_pkg::NODE_W-1:0]  par_raddr, par_waddr;
  logic [huff_pkg::NODE_W:0]    par_rd_q, par_wdata;
  logic                         par_we;

  // code memory: {length, bits}
  logic [CODE_E_W-1:0]          code_mem [huff_pkg::SYMBOLS];
  logic [huff_pkg::SYMBOLS-1:0] code_vld_q;
  logic [huff_pkg::SYM_W-1:0]   code_raddr, code_waddr;
  logic [CODE_E_W-1:0]          code_rd_q, code_wdata;
  logic                         code_vld_rd_q, code_we;

  logic                         out_free;
  logic [huff_pkg::DIST_W-1:0]  n_next, m_dec;
  logic [huff_pkg::LEN_W-1:0]   enc_len;
  huff_pkg::chunk_t             chunk;

  huff_chunk u_chunk (
    .bits_i (bits_q),
    .rem_i  (len_q),
    .chunk_o(chunk)
  );

  always_ff @(posedge clk_i) begin
    cnt_rd_q     <= cnt_mem[cnt_raddr];
    cnt_vld_rd_q <= cnt_vld_q[cnt_raddr];
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    wgt_rd_q <= wgt_mem[wgt_raddr];
    if (wgt_we) begin
      wgt_mem[wgt_waddr] <= wgt_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    que_rd_q <= que_mem[que_raddr];
    if (que_we) begin
      que_mem[que_waddr] <= que_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    par_rd_q <= par_mem[par_raddr];
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    code_rd_q     <= code_mem[code_raddr];
    code_vld_rd_q <= code_vld_q[code_raddr];
    if (code_we) begin
      code_mem[code_waddr] <= code_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q  <= '0;
      code_vld_q <= '0;
    end else begin
      if (cnt_we) begin
        cnt_vld_q[cnt_waddr] <= 1'b1;
      end
      if (code_we) begin
        code_vld_q[code_waddr] <= 1'b1;
      end
    end
  end

  assign cnt_val  = cnt_vld_rd_q ? cnt_rd_q : '0;
  assign out_free = !out_vld_q || !out_stall_i;
  assign n_next   = n_q + ((cnt_val != '0) ? 8'd1 : 8'd0);
  assign m_dec    = m_q - 8'd1;
  assign enc_len  = (usable_q && code_vld_rd_q) ? code_rd_q[CODE_E_W-1 -: huff_pkg::LEN_W]
                                                 : '0;

  always_comb begin
    state_d = state_q;
    s_d = s_q; sym_d = sym_q; usable_d = usable_q;
    n_d = n_q; m_d = m_q; dist_d = dist_q;
    i_d = i_q; j_d = j_q;
    next_d = next_q; node_d = node_q; root_d = root_q;
    t_d = t_q; qv_d = qv_q; tw_d = tw_q;
    len_d = len_q; bits_d = bits_q;

    out_vld_d   = out_vld_q && out_stall_i;
    out_chunk_d = out_chunk_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    out_dist_d  = out_dist_q;

    cnt_raddr = sym_q; cnt_waddr = sym_q; cnt_wdata = '0; cnt_we = 1'b0;
    wgt_raddr = t_q; wgt_waddr = next_q; wgt_wdata = '0; wgt_we = 1'b0;
    que_raddr = i_q; que_waddr = j_q; que_wdata = t_q; que_we = 1'b0;
    par_raddr = node_q; par_waddr = t_q; par_wdata = '0; par_we = 1'b0;
    code_raddr = sym_q; code_waddr = s_q; code_wdata = '0; code_we = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sym_d    = symbol_i;
          usable_d = !huff_pkg::is_space(symbol_i);
          case (cmd_i)
            huff_pkg::CMD_COUNT: begin
              cnt_raddr = symbol_i;
              state_d   = ST_CT_WR;
            end
            huff_pkg::CMD_BUILD: begin
              s_d     = '0;
              n_d     = '0;
              state_d = ST_SC_RD;
            end
            huff_pkg::CMD_ENCODE: begin
              code_raddr = symbol_i;
              state_d    = ST_EN_LD;
            end
            default: state_d = ST_ACK;
          endcase
        end
      end
      ST_CT_WR: begin
        if (usable_q && (cnt_val != huff_pkg::COUNT_MAX)) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_val + 32'd1;
        end
        state_d = ST_ACK;
      end
      ST_ACK: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_chunk_d = '0;
          out_len_d   = '0;
          out_last_d  = 1'b1;
          out_dist_d  = dist_q;
          state_d     = ST_IDLE;
        end
      end
      ST_SC_RD: begin
        cnt_raddr = s_q;
        state_d   = ST_SC_WR;
      end
      ST_SC_WR: begin
        if (cnt_val != '0) begin
          wgt_we    = 1'b1;
          wgt_waddr = {1'b0, s_q};
          wgt_wdata = cnt_val;
          que_we    = 1'b1;
          que_waddr = n_q[huff_pkg::SYM_W-1:0];
          que_wdata = {1'b0, s_q};
        end
        n_d = n_next;
        s_d = s_q + 7'd1;
        if (s_q == 7'd127) begin
          dist_d = n_next;
          m_d    = n_next;
          next_d = 8'd128;
          i_d    = 7'd1;
          state_d = (n_next >= 8'd2) ? ST_SO_I : ST_RT_A;
        end else begin
          state_d = ST_SC_RD;
        end
      end
      ST_SO_I: begin
        que_raddr = i_q;
        state_d   = ST_SO_T;
      end
      ST_SO_T: begin
        t_d       = que_rd_q;
        wgt_raddr = que_rd_q;
        state_d   = ST_SO_TW;
      end
      ST_SO_TW: begin
        tw_d    = wgt_rd_q;
        j_d     = i_q;
        state_d = ST_SO_J;
      end
      ST_SO_J: begin
        if (j_q == 7'd0) begin
          que_we    = 1'b1;
          que_waddr = '0;
          que_wdata = t_q;
          if (({1'b0, i_q} + 8'd1) < m_q) begin
            i_d     = i_q + 7'd1;
            state_d = ST_SO_I;
          end else begin
            state_d = ST_MG_A;
          end
        end else begin
          que_raddr = j_q - 7'd1;
          state_d   = ST_SO_Q;
        end
      end
      ST_SO_Q: begin
        qv_d      = que_rd_q;
        wgt_raddr = que_rd_q;
        state_d   = ST_SO_C;
      end
      ST_SO_C: begin
        que_we    = 1'b1;
        que_waddr = j_q;
        if (tw_q >= wgt_rd_q) begin
          que_wdata = qv_q;
          j_d       = j_q - 7'd1;
          state_d   = ST_SO_J;
        end else begin
          que_wdata = t_q;
          if (({1'b0, i_q} + 8'd1) < m_q) begin
            i_d     = i_q + 7'd1;
            state_d = ST_SO_I;
          end else begin
            state_d = ST_MG_A;
          end
        end
      end
      ST_MG_A: begin
        que_raddr = m_dec[huff_pkg::SYM_W-1:0];
        state_d   = ST_MG_B;
      end
      ST_MG_B: begin
        t_d       = que_rd_q;
        wgt_raddr = que_rd_q;
        que_raddr = 7'(m_q - 8'd2);
        state_d   = ST_MG_C;
      end
      ST_MG_C: begin
        qv_d      = que_rd_q;
        tw_d      = wgt_rd_q;
        wgt_raddr = que_rd_q;
        state_d   = ST_MG_D;
      end
      ST_MG_D: begin
        wgt_we    = 1'b1;
        wgt_waddr = next_q;
        wgt_wdata = huff_pkg::sat_add(tw_q, wgt_rd_q);
        par_we    = 1'b1;
        par_waddr = t_q;
        par_wdata = {1'b1, next_q};
        que_we    = 1'b1;
        que_waddr = 7'(m_q - 8'd2);
        que_wdata = next_q;
        state_d   = ST_MG_E;
      end
      ST_MG_E: begin
        par_we    = 1'b1;
        par_waddr = qv_q;
        par_wdata = {1'b0, next_q};
        next_d    = next_q + 8'd1;
        m_d       = m_dec;
        i_d       = 7'd1;
        state_d   = (m_dec >= 8'd2) ? ST_SO_I : ST_RT_A;
      end
      ST_RT_A: begin
        que_raddr = '0;
        state_d   = ST_RT_B;
      end
      ST_RT_B: begin
        root_d  = que_rd_q;
        s_d     = '0;
        state_d = ST_CD_RD;
      end
      ST_CD_RD: begin
        cnt_raddr = s_q;
        state_d   = ST_CD_CHK;
      end
      ST_CD_CHK: begin
        if (cnt_val == '0) begin
          code_we    = 1'b1;
          code_waddr = s_q;
          code_wdata = '0;
          s_d        = s_q + 7'd1;
          state_d    = (s_q == 7'd127) ? ST_ACK : ST_CD_RD;
        end else begin
          node_d  = {1'b0, s_q};
          len_d   = '0;
          bits_d  = '0;
          state_d = ST_CD_W;
        end
      end
      ST_CD_W: begin
        if ((node_q == root_q) || (len_q == 7'd127)) begin
          code_we    = 1'b1;
          code_waddr = s_q;
          code_wdata = {len_q, bits_q};
          s_d        = s_q + 7'd1;
          state_d    = (s_q == 7'd127) ? ST_ACK : ST_CD_RD;
        end else begin
          par_raddr = node_q;
          state_d   = ST_CD_P;
        end
      end
      ST_CD_P: begin
        if (par_rd_q[huff_pkg::NODE_W]) begin
          bits_d[len_q] = 1'b1;
        end
        len_d   = len_q + 7'd1;
        node_d  = par_rd_q[huff_pkg::NODE_W-1:0];
        state_d = ST_CD_W;
      end
      ST_EN_LD: begin
        if (enc_len == '0) begin
          state_d = ST_ACK;
        end else begin
          bits_d  = code_rd_q[huff_pkg::CODE_W-1:0];
          len_d   = enc_len;
          state_d = ST_EN_OUT;
        end
      end
      ST_EN_OUT: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_chunk_d = chunk.value;
          out_len_d   = chunk.len;
          out_last_d  = chunk.last;
          out_dist_d  = dist_q;
          len_d       = len_q - {1'b0, chunk.len};
          if (chunk.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      dist_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dist_q    <= dist_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d; sym_q <= sym_d; usable_q <= usable_d;
    n_q <= n_d; m_q <= m_d;
    i_q <= i_d; j_q <= j_d;
    next_q <= next_d; node_q <= node_d; root_q <= root_d;
    t_q <= t_d; qv_q <= qv_d; tw_q <= tw_d;
    len_q <= len_d; bits_q <= bits_d;
    out_chunk_q <= out_chunk_d;
    out_len_q   <= out_len_d;
    out_last_q  <= out_last_d;
    out_dist_q  <= out_dist_d;
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_vld_q;
  assign code_chunk_o       = out_chunk_q;
  assign chunk_length_o     = out_len_q;
  assign last_chunk_o       = out_last_q;
  assign distinct_symbols_o = out_dist_q;

endmodule

/* rtl/huff_checker.sv */
`timescale 1ns / 1ps
`include "huffman_two_pass_encoder_core_macros.svh"
module huff_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] code_chunk_o,
  input logic [5:0]  chunk_length_o,
  input logic        last_chunk_o,
  input logic [7:0]  distinct_symbols_o
);

  `HUFF_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(code_chunk_o) && $stable(chunk_length_o))
  `HUFF_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `HUFF_ASSERT_IMP(a_empty_is_last, out_valid_o && (chunk_length_o == 6'd0), last_chunk_o && (code_chunk_o == 32'd0))
  `HUFF_ASSERT_IMP(a_ranges, out_valid_o, (chunk_length_o <= 6'd32) && (distinct_symbols_o <= 8'd128))

endmodule

bind huffman_two_pass_encoder_core huff_checker u_huff_checker (.*);

/* sim/tb_huffman_two_pass_encoder_core.sv */
`timescale 1ns / 1ps
module tb_huffman_two_pass_encoder_core;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int IDLE_LIMIT = 400000;
  localparam int POOL_N = 14;

  typedef struct packed {
    huff_pkg::chunk_t chunk;
    logic [7:0]       dcount;
  } enc_result_t;

  typedef struct {
    logic [1:0] cmd;
    logic [6:0] sym;
    bit         typed;
    logic [7:0] dcount;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = '0;
  logic [6:0]  symbol_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] code_chunk_o;
  logic [5:0]  chunk_length_o;
  logic        last_chunk_o;
  logic [7:0]  distinct_symbols_o;

  huffman_two_pass_encoder_core i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .symbol_i           (symbol_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .code_chunk_o       (code_chunk_o),
    .chunk_length_o     (chunk_length_o),
    .last_chunk_o       (last_chunk_o),
    .distinct_symbols_o (distinct_symbols_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [huff_pkg::COUNT_W-1:0] sym_count [huff_pkg::SYMBOLS];
  logic [huff_pkg::LEN_W-1:0]   code_len [huff_pkg::SYMBOLS];
  logic [huff_pkg::CODE_W-1:0]  code_val [huff_pkg::SYMBOLS];
  logic [7:0]                   distinct;
  logic [huff_pkg::COUNT_W-1:0] tree_wt [huff_pkg::NODES];
  int                           tree_q [huff_pkg::NODES];

  enc_result_t pending_q[$];
  int  errors = 0;
  int  send_idle = 0;
  int  recv_stall = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  logic [6:0] pool [POOL_N];

  function automatic bit usable(logic [6:0] s);
    return !huff_pkg::is_space(s);
  endfunction

  function automatic void sort_by_weight(int n);
    int t, j;
    for (int i = 1; i < n; i++) begin
      t = tree_q[i];
      j = i;
      while (j > 0 && tree_wt[t] >= tree_wt[tree_q[j-1]]) begin
        tree_q[j] = tree_q[j-1];
        j--;
      end
      tree_q[j] = t;
    end
  endfunction

  function automatic void build_codes();
    int par [huff_pkg::NODES];
    bit pbit [huff_pkg::NODES];
    int n, m, nxt, one, zero, root, node, len;
    logic [huff_pkg::COUNT_W:0] sum;
    logic [huff_pkg::CODE_W-1:0] bits;
    n = 0;
    nxt = huff_pkg::SYMBOLS;
    for (int s = 0; s < huff_pkg::SYMBOLS; s++) begin
      code_len[s] = '0;
      if (sym_count[s] != 0) begin
        tree_wt[s] = sym_count[s];
        tree_q[n] = s;
        n++;
      end
    end
    distinct = n[7:0];
    if (n == 0) return;
    for (int i = 0; i < huff_pkg::NODES; i++) par[i] = -1;
    m = n;
    sort_by_weight(m);
    while (m >= 2 && nxt < huff_pkg::NODES) begin
      one = tree_q[m-1];
      zero = tree_q[m-2];
      sum = {1'b0, tree_wt[one]} + {1'b0, tree_wt[zero]};
      tree_wt[nxt] = sum[huff_pkg::COUNT_W] ? huff_pkg::COUNT_MAX
                                             : sum[huff_pkg::COUNT_W-1:0];
      par[one] = nxt;
      pbit[one] = 1'b1;
      par[zero] = nxt;
      pbit[zero] = 1'b0;
      tree_q[m-2] = nxt;
      nxt++;
      m--;
      sort_by_weight(m);
    end
    root = tree_q[0];
    for (int s = 0; s < huff_pkg::SYMBOLS; s++) begin
      if (sym_count[s] != 0) begin
        bits = '0;
        len = 0;
        node = s;
        while (node != root && par[node] != -1 && len < 127) begin
          bits[len] = pbit[node];
          len++;
          node = par[node];
        end
        code_val[s] = bits;
        code_len[s] = len[huff_pkg::LEN_W-1:0];
      end
    end
  endfunction

  function automatic void push_result(logic [31:0] v, int len, bit last);
    enc_result_t r;
    r.chunk.value = v;
    r.chunk.len = len[huff_pkg::CHUNK_LEN_W-1:0];
    r.chunk.last = last;
    r.dcount = distinct;
    pending_q = {pending_q, r};
  endfunction

  function automatic void predict_item(logic [1:0] cmd, logic [6:0] s);
    int len, chunks, start, cnt;
    logic [31:0] v;
    case (cmd)
      huff_pkg::CMD_COUNT: begin
        if (usable(s) && sym_count[s] != huff_pkg::COUNT_MAX) sym_count[s]++;
        push_result('0, 0, 1'b1);
      end
      huff_pkg::CMD_BUILD: begin
        build_codes();
        push_result('0, 0, 1'b1);
      end
      huff_pkg::CMD_ENCODE: begin
        len = usable(s) ? int'(code_len[s]) : 0;
        if (len == 0) begin
          push_result('0, 0, 1'b1);
        end else begin
          chunks = (len + huff_pkg::CHUNK_W - 1) / huff_pkg::CHUNK_W;
          if (chunks > 4) chunks = 4;
          start = 0;
          for (int k = 0; k < chunks; k++) begin
            cnt = len - start;
            if (cnt > huff_pkg::CHUNK_W) cnt = huff_pkg::CHUNK_W;
            v = '0;
            for (int t = 0; t < cnt; t++) v = {v[30:0], code_val[s][len-1-(start+t)]};
            push_result(v, cnt, k + 1 == chunks);
            start += cnt;
          end
        end
      end
      default: push_result('0, 0, 1'b1);
    endcase
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [6:0] s, bit typed, logic [7:0] dcount);
    int mark;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    symbol_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mark = pending_q.size();
    predict_item(cmd, s);
    if (typed) begin
      while (pending_q.size() > mark) void'(pending_q.pop_back());
      push_result('0, 0, 1'b1);
      pending_q[pending_q.size()-1].dcount = dcount;
    end
  endtask

  task automatic random_round(int counts, int encodes);
    logic [1:0] c;
    logic [6:0] s;
    int hot;
    hot = $urandom_range(POOL_N - 1);
    for (int i = 0; i < counts; i++) begin
      s = ($urandom_range(2) == 0) ? pool[hot] : pool[$urandom_range(POOL_N - 1)];
      if ($urandom_range(9) == 0) s = 7'd32;
      send_item(huff_pkg::CMD_COUNT, s, 1'b0, '0);
    end
    send_item(huff_pkg::CMD_BUILD, 7'($urandom), 1'b0, '0);
    for (int i = 0; i < encodes; i++) begin
      c = ($urandom_range(7) == 0) ? CMD_NOP : huff_pkg::CMD_ENCODE;
      s = ($urandom_range(2) == 0) ? 7'($urandom) : pool[$urandom_range(POOL_N - 1)];
      send_item(c, s, 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall);
    end
  end

  always @(posedge clk_i) begin
    enc_result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.chunk.value = code_chunk_o;
      got.chunk.len = chunk_length_o;
      got.chunk.last = last_chunk_o;
      got.dcount = distinct_symbols_o;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.chunk.value !== want.chunk.value) begin
          $display("%0t: code_chunk expected %h actual %h", $time, want.chunk.value,
                   got.chunk.value);
          errors++;
        end
        if (got.chunk.len !== want.chunk.len) begin
          $display("%0t: chunk_length expected %0d actual %0d", $time, want.chunk.len,
                   got.chunk.len);
          errors++;
        end
        if (got.chunk.last !== want.chunk.last) begin
          $display("%0t: last_chunk expected %b actual %b", $time, want.chunk.last,
                   got.chunk.last);
          errors++;
        end
        if (got.dcount !== want.dcount) begin
          $display("%0t: distinct_symbols expected %0d actual %0d", $time, want.dcount,
                   got.dcount);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    int settle;
    for (int s = 0; s < huff_pkg::SYMBOLS; s++) begin
      sym_count[s] = '0;
      code_len[s] = '0;
      code_val[s] = '0;
    end
    distinct = '0;
    pool[0] = 7'd0;
    pool[1] = 7'd127;
    for (int i = 2; i < POOL_N; i++) pool[i] = 7'($urandom);

    rows = '{
      '{huff_pkg::CMD_ENCODE, 7'd5,   1'b1, 8'd0},
      '{huff_pkg::CMD_BUILD,  7'd0,   1'b1, 8'd0},
      '{huff_pkg::CMD_COUNT,  7'd0,   1'b1, 8'd0},
      '{huff_pkg::CMD_BUILD,  7'd0,   1'b1, 8'd1},
      '{huff_pkg::CMD_ENCODE, 7'd0,   1'b1, 8'd1},
      '{huff_pkg::CMD_COUNT,  7'd127, 1'b1, 8'd1},
      '{huff_pkg::CMD_COUNT,  7'd32,  1'b1, 8'd1},
      '{huff_pkg::CMD_COUNT,  7'd9,   1'b1, 8'd1},
      '{huff_pkg::CMD_COUNT,  7'd13,  1'b1, 8'd1},
      '{CMD_NOP,              7'd64,  1'b1, 8'd1},
      '{huff_pkg::CMD_COUNT,  7'd127, 1'b0, 8'd0},
      '{huff_pkg::CMD_COUNT,  7'd66,  1'b0, 8'd0},
      '{huff_pkg::CMD_BUILD,  7'd127, 1'b0, 8'd0},
      '{huff_pkg::CMD_ENCODE, 7'd127, 1'b0, 8'd0},
      '{huff_pkg::CMD_ENCODE, 7'd0,   1'b0, 8'd0},
      '{huff_pkg::CMD_ENCODE, 7'd66,  1'b0, 8'd0},
      '{huff_pkg::CMD_ENCODE, 7'd32,  1'b1, 8'd3},
      '{huff_pkg::CMD_ENCODE, 7'd100, 1'b1, 8'd3}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) send_item(rows[i].cmd, rows[i].sym, rows[i].typed, rows[i].dcount);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? 87 : 0;
      recv_stall = (ph == 2) ? 87 : (ph == 3) ? 34 : 0;
      if (ph == 3) send_idle = 34;
      if (ph == 0) hold_left = 300;
      random_round(7 + $urandom_range(3), 4 + $urandom_range(3));
      random_round(4 + $urandom_range(2), 3 + $urandom_range(2));
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    recv_stall = 0;
    settle = 0;
    while (pending_q.size() != 0 && settle < IDLE_LIMIT) begin
      @(posedge clk_i);
      settle++;
    end
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/huff_pkg.sv
rtl/huff_chunk.sv
rtl/huffman_two_pass_encoder_core.sv
rtl/huff_checker.sv
sim/tb_huffman_two_pass_encoder_core.sv
